FILE: sv/tses_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tses_pkg
// Shared types, constants and term helpers for the series evaluator.
// ----------------------------------------------------------------------------
package tses_pkg;

  localparam int X_W          = 18;
  localparam int X_FRAC_BITS  = 16;
  localparam int XMAG_W       = 17;
  localparam int P_W          = 31;
  localparam int TI_W         = 7;
  localparam int IDX_OUT_W    = 5;
  localparam int VAL_W        = 32;
  localparam int EST_W        = 24;
  localparam int TOL_W        = 16;
  localparam int TCNT_W       = 5;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int MUL_A_W      = 32;
  localparam int MUL_B_W      = 17;
  localparam int PROD_W       = 49;
  localparam int DIV_R_W      = 33;
  localparam int DIV_Q_W      = 32;
  localparam int DIV_N_W      = 6;
  localparam int PC_W         = 4;

  localparam logic signed [X_W-1:0] X_ONE = X_W'(64'd1 << X_FRAC_BITS);
  localparam logic [VAL_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] NEG_MAG = 32'h8000_0000;
  localparam logic [EST_W-1:0] EST_MAX = 24'hFF_FFFF;
  localparam logic [DIV_N_W-1:0] N_DIV_STEPS   = 6'd32;
  localparam logic [DIV_N_W-1:0] EST_DIV_STEPS = 6'd24;

  localparam logic TOL_RESET_UNUSED = 1'b0;
  localparam logic [TCNT_W-1:0] TCNT_RESET = 5'd7;
  localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd66;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STOP_MODE  = 2'd0,
    CFG_TERM_COUNT = 2'd1,
    CFG_TOLERANCE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_TERM,
    OP_ADD,
    OP_DIVWAIT,
    OP_NEXT,
    OP_EST,
    OP_EMIT,
    OP_ZERO
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_X_ZERO,
    COND_EST_SAT,
    COND_MORE
  } cond_t;

  typedef enum logic [PC_W-1:0] {
    ST_IDLE,
    ST_TERM,
    ST_ADD,
    ST_DIVN,
    ST_NEXT,
    ST_EST,
    ST_DIVE,
    ST_EMIT,
    ST_DONE,
    ST_ZERO
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic stall;
    logic x_zero;
    logic est_sat;
    logic last;
  } status_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_R_W-1:0]   rem;
    logic [DIV_Q_W-1:0]   quo;
    logic [DIV_Q_W-1:0]   divisor;
    logic [DIV_N_W-1:0]   steps;
  } div_req_t;

  // sign of term idx given the sign of x^(idx+1)/idx!
  function automatic logic term_neg(input logic pneg, input logic [TI_W-1:0] idx);
    term_neg = pneg ^ (idx[2:0] >= 3'd5);
  endfunction

  // saturated magnitude of term idx, Q3.28, from x^(idx+1)/idx! in Q1.30
  function automatic logic [VAL_W-1:0] term_mag(input logic [P_W-1:0] pmag,
                                                input logic pneg,
                                                input logic [TI_W-1:0] idx);
    logic [63:0]      wide;
    logic [63:0]      v;
    logic [VAL_W-1:0] cap;
    wide = {33'd0, pmag} << idx[TI_W-1:1];
    v    = (wide + 64'd2) >> 2;
    cap  = term_neg(pneg, idx) ? NEG_MAG : POS_MAX;
    if (idx[1:0] == 2'd0) begin
      term_mag = '0;
    end else if (v > {32'd0, cap}) begin
      term_mag = cap;
    end else begin
      term_mag = v[VAL_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/tses_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tses_in_if / tses_out_if
// Valid/ready channels for the argument and for the per-term results.
// ----------------------------------------------------------------------------
interface tses_in_if;
  import tses_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [X_W-1:0]   x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface tses_out_if;
  import tses_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [IDX_OUT_W-1:0]      term_index;
  logic signed [VAL_W-1:0]   term_value;
  logic signed [VAL_W-1:0]   running_sum;
  logic [EST_W-1:0]          error_estimate;
  logic                      last_term;

  modport source (output valid, output term_index, output term_value,
                  output running_sum, output error_estimate, output last_term,
                  input ready);
  modport sink   (input valid, input term_index, input term_value,
                  input running_sum, input error_estimate, input last_term,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/tses_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tses_rom
// Microcode program: one control word per step of the sequencer.
// ----------------------------------------------------------------------------
module tses_rom (
  input  tses_pkg::step_t pc,
  output tses_pkg::ctrl_t ctrl
);
  import tses_pkg::*;

  always_comb begin
    case (pc)
      ST_IDLE: ctrl = '{op: OP_LOAD,    cond: COND_X_ZERO,  target: ST_ZERO};
      ST_TERM: ctrl = '{op: OP_TERM,    cond: COND_NEXT,    target: ST_IDLE};
      ST_ADD:  ctrl = '{op: OP_ADD,     cond: COND_NEXT,    target: ST_IDLE};
      ST_DIVN: ctrl = '{op: OP_DIVWAIT, cond: COND_NEXT,    target: ST_IDLE};
      ST_NEXT: ctrl = '{op: OP_NEXT,    cond: COND_NEXT,    target: ST_IDLE};
      // skip the divide when the estimate saturates
      ST_EST:  ctrl = '{op: OP_EST,     cond: COND_EST_SAT, target: ST_EMIT};
      ST_DIVE: ctrl = '{op: OP_DIVWAIT, cond: COND_NEXT,    target: ST_IDLE};
      ST_EMIT: ctrl = '{op: OP_EMIT,    cond: COND_MORE,    target: ST_TERM};
      ST_DONE: ctrl = '{op: OP_NOP,     cond: COND_JUMP,    target: ST_IDLE};
      ST_ZERO: ctrl = '{op: OP_ZERO,    cond: COND_JUMP,    target: ST_IDLE};
      default: ctrl = '{op: OP_NOP,     cond: COND_JUMP,    target: ST_IDLE};
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/tses_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tses_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tses_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tses_pkg::div_req_t               req,
  output logic                             busy,
  output logic [tses_pkg::DIV_Q_W-1:0]     quo
);
  import tses_pkg::*;

  logic [DIV_R_W-1:0] rem_r;
  logic [DIV_Q_W-1:0] quo_r;
  logic [DIV_Q_W-1:0] dsr_r;
  logic [DIV_N_W-1:0] cnt_r;
  logic [DIV_R_W-1:0] shifted;
  logic [DIV_R_W-1:0] diff;
  logic               ge;

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

  always_comb begin
    shifted = {rem_r[DIV_R_W-2:0], quo_r[DIV_Q_W-1]};
    ge      = (shifted >= {1'b0, dsr_r});
    diff    = shifted - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= req.steps;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem;
      quo_r <= req.quo;
      dsr_r <= req.divisor;
    end else if (busy) begin
      rem_r <= ge ? diff : shifted;
      quo_r <= {quo_r[DIV_Q_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

FILE: sv/tses_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tses_dp
// Datapath: configuration, term and sum registers, shared multiplier,
// divider and the output register; the control word drives all but the configuration.
// ----------------------------------------------------------------------------
module tses_dp #(
  parameter int MAX_TERMS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tses_pkg::ctrl_t                    ctrl,
  output tses_pkg::status_t                  st,
  tses_in_if.sink                            in_ch,
  tses_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [tses_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tses_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tses_pkg::*;

  localparam int CW = ($clog2(MAX_TERMS + 1) > 6) ? $clog2(MAX_TERMS + 1) : 6;

  // configuration
  logic              stop_mode_r;
  logic [TCNT_W-1:0] term_count_r;
  logic [TOL_W-1:0]  tol_r;

  // run state
  logic [XMAG_W-1:0]       xmag_r;
  logic                    xneg_r;
  logic [P_W-1:0]          pmag_r;
  logic                    pneg_r;
  logic [P_W-1:0]          nmag_r;
  logic                    nneg_r;
  logic [CW-1:0]           idx_r;
  logic [CW-1:0]           limit_r;
  logic signed [VAL_W-1:0] term_r;
  logic signed [VAL_W-1:0] sum_r;
  logic [VAL_W-1:0]        anext_r;
  logic [VAL_W-1:0]        asum_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    est_sat_r;

  // output register
  logic                    out_valid_r;
  logic [IDX_OUT_W-1:0]    out_index_r;
  logic signed [VAL_W-1:0] out_term_r;
  logic signed [VAL_W-1:0] out_sum_r;
  logic [EST_W-1:0]        out_est_r;
  logic                    out_last_r;

  logic signed [X_W-1:0]   xc;
  logic [X_W-1:0]          xabs;
  logic                    x_zero;
  logic [CW-1:0]           cnt1;
  logic [CW-1:0]           lim;
  logic [CW-1:0]           idx_p1;
  logic [VAL_W-1:0]        t_mag;
  logic signed [VAL_W-1:0] term_val;
  logic signed [VAL_W:0]   sum_w;
  logic signed [VAL_W-1:0] sum_sat;
  logic [PROD_W-1:0]       dvd_w;
  logic [P_W-1:0]          n_mag;
  logic                    n_neg;
  logic [VAL_W-1:0]        a_next;
  logic [VAL_W-1:0]        a_sum;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       prod_c;
  logic                    est_sat;
  logic                    last;
  logic                    out_free;
  logic                    div_busy;
  logic [DIV_Q_W-1:0]      div_quo;
  div_req_t                div_req;

  // argument clamp to +-1.0
  always_comb begin
    if (in_ch.x_value > X_ONE) begin
      xc = X_ONE;
    end else if (in_ch.x_value < -X_ONE) begin
      xc = -X_ONE;
    end else begin
      xc = in_ch.x_value;
    end
    xabs   = xc[X_W-1] ? X_W'(-xc) : X_W'(xc);
    x_zero = (xc == '0);
  end

  always_comb begin
    cnt1   = CW'(term_count_r) + CW'(1);
    if (stop_mode_r || (cnt1 >= CW'(MAX_TERMS))) begin
      lim = CW'(MAX_TERMS);
    end else begin
      lim = cnt1;
    end
    idx_p1 = idx_r + CW'(1);
  end

  always_comb begin
    t_mag    = term_mag(pmag_r, pneg_r, TI_W'(idx_r));
    term_val = term_neg(pneg_r, TI_W'(idx_r)) ? -$signed(t_mag) : $signed(t_mag);
    sum_w    = {sum_r[VAL_W-1], sum_r} + {term_r[VAL_W-1], term_r};
    if (sum_w[VAL_W] != sum_w[VAL_W-1]) begin
      sum_sat = sum_w[VAL_W] ? $signed(NEG_MAG) : $signed(POS_MAX);
    end else begin
      sum_sat = sum_w[VAL_W-1:0];
    end
    // p*x / 2^frac divided by i+1, rounded to nearest by a half-divisor offset
    dvd_w  = prod_r + (PROD_W'(idx_p1) << (X_FRAC_BITS - 1));
    n_mag  = div_quo[P_W-1:0];
    n_neg  = (n_mag != '0) && (pneg_r != xneg_r);
    a_next = term_mag(n_mag, n_neg, TI_W'(idx_p1));
    a_sum  = sum_r[VAL_W-1] ? (VAL_W'(0) - $unsigned(sum_r)) : $unsigned(sum_r);
  end

  always_comb begin
    if (ctrl.op == OP_EST) begin
      mul_a = asum_r;
      mul_b = {1'b0, tol_r};
    end else begin
      mul_a = {1'b0, pmag_r};
      mul_b = xmag_r;
    end
    prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    est_sat  = (asum_r == '0) || ({8'd0, anext_r} >= {asum_r, 8'd0});
    last     = (idx_p1 >= limit_r) ||
               (stop_mode_r && ({1'b0, anext_r, 16'd0} <= prod_r));
    out_free = !out_valid_r || out_ch.ready;
  end

  always_comb begin
    div_req.start = (ctrl.op == OP_ADD) || ((ctrl.op == OP_EST) && !est_sat);
    if (ctrl.op == OP_EST) begin
      div_req.rem     = {9'd0, anext_r[VAL_W-1:8]};
      div_req.quo     = {anext_r[7:0], 24'd0};
      div_req.divisor = asum_r;
      div_req.steps   = EST_DIV_STEPS;
    end else begin
      div_req.rem     = '0;
      div_req.quo     = dvd_w[X_FRAC_BITS +: DIV_Q_W];
      div_req.divisor = DIV_Q_W'(idx_p1);
      div_req.steps   = N_DIV_STEPS;
    end
  end

  tses_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_comb begin
    case (ctrl.op)
      OP_LOAD:    st.stall = !in_ch.valid;
      OP_DIVWAIT: st.stall = div_busy;
      OP_EMIT:    st.stall = !out_free;
      OP_ZERO:    st.stall = !out_free;
      default:    st.stall = 1'b0;
    endcase
    st.x_zero  = x_zero;
    st.est_sat = est_sat;
    st.last    = last;
  end

  assign in_ch.ready           = (ctrl.op == OP_LOAD);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.term_index     = out_index_r;
  assign out_ch.term_value     = out_term_r;
  assign out_ch.running_sum    = out_sum_r;
  assign out_ch.error_estimate = out_est_r;
  assign out_ch.last_term      = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_mode_r  <= TOL_RESET_UNUSED;
      term_count_r <= TCNT_RESET;
      tol_r        <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_STOP_MODE:  stop_mode_r  <= cfg_wdata[0];
        CFG_TERM_COUNT: term_count_r <= cfg_wdata[TCNT_W-1:0];
        CFG_TOLERANCE:  tol_r        <= cfg_wdata[TOL_W-1:0];
        default:        stop_mode_r  <= stop_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (((ctrl.op == OP_EMIT) || (ctrl.op == OP_ZERO)) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        xmag_r  <= xabs[XMAG_W-1:0];
        xneg_r  <= xc[X_W-1];
        pmag_r  <= P_W'(xabs[XMAG_W-1:0]) << (30 - X_FRAC_BITS);
        pneg_r  <= xc[X_W-1];
        idx_r   <= '0;
        limit_r <= lim;
        sum_r   <= '0;
      end
      OP_TERM: begin
        term_r <= term_val;
        prod_r <= prod_c;
      end
      OP_ADD: begin
        sum_r <= sum_sat;
      end
      OP_NEXT: begin
        nmag_r  <= n_mag;
        nneg_r  <= n_neg;
        anext_r <= a_next;
        asum_r  <= a_sum;
      end
      OP_EST: begin
        prod_r    <= prod_c;
        est_sat_r <= est_sat;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_index_r <= idx_r[IDX_OUT_W-1:0];
          out_term_r  <= term_r;
          out_sum_r   <= sum_r;
          out_est_r   <= est_sat_r ? EST_MAX : div_quo[EST_W-1:0];
          out_last_r  <= last;
          pmag_r      <= nmag_r;
          pneg_r      <= nneg_r;
          idx_r       <= idx_p1;
        end
      end
      OP_ZERO: begin
        if (out_free) begin
          out_index_r <= '0;
          out_term_r  <= '0;
          out_sum_r   <= '0;
          out_est_r   <= '0;
          out_last_r  <= 1'b1;
        end
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/taylor_series_exp_sin_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// taylor_series_exp_sin_evaluator
// Series evaluator for x*e^x*sin(x) with one result per summed term.
// ----------------------------------------------------------------------------
// in_ch carries one Q1.16 argument per item; out_ch returns one item per
// term: index, term, saturating running sum, |next term / sum| and a last
// flag on the final item of the run. cfg_we/cfg_addr/cfg_wdata write
// stop_mode (0), term_count (1) and tolerance (2); write them while idle.
// A microcoded sequencer runs a ten-step program over one multiplier and
// one shift-subtract divider. Each term runs the 32-step divide that gives
// the next power-over-factorial, the 24-step estimate divide and five other
// steps; a term whose estimate saturates skips the estimate divide. A zero
// argument goes from the idle step to the zero step, which registers one
// all-zero item flagged as last. The next argument is taken only after the
// last item of a run is in the output register.
// The output register holds a result until out_ch.ready; while it waits,
// the sequencer stalls at its next emit or zero step. Reset (synchronous, rst_n
// low) empties the output register, returns the program to its idle step
// and restores stop_mode 0, term_count 7, tolerance 66.
// ----------------------------------------------------------------------------
module taylor_series_exp_sin_evaluator #(
  parameter int MAX_TERMS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tses_in_if.sink                            in_ch,
  tses_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [tses_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tses_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tses_pkg::*;

  step_t   pc_r;
  step_t   pc_nxt;
  step_t   pc_inc;
  ctrl_t   ctrl;
  status_t st;

  tses_rom u_rom (
    .pc   (pc_r),
    .ctrl (ctrl)
  );

  tses_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .st        (st),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  assign pc_inc = step_t'(pc_r + 1'b1);

  always_comb begin
    pc_nxt = pc_r;
    if (!st.stall) begin
      case (ctrl.cond)
        COND_NEXT:    pc_nxt = pc_inc;
        COND_JUMP:    pc_nxt = ctrl.target;
        COND_X_ZERO:  pc_nxt = st.x_zero ? ctrl.target : pc_inc;
        COND_EST_SAT: pc_nxt = st.est_sat ? ctrl.target : pc_inc;
        COND_MORE:    pc_nxt = st.last ? pc_inc : ctrl.target;
        default:      pc_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/tses_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tses_chk
// Port-level checks for the series evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module tses_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_last,
  input logic [tses_pkg::IDX_OUT_W-1:0]  out_index,
  input logic [tses_pkg::VAL_W-1:0]      out_term,
  input logic [tses_pkg::VAL_W-1:0]      out_sum,
  input logic [tses_pkg::EST_W-1:0]      out_est
);
  import tses_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one argument at a time: no second item right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // while a non-final result waits, the run is still going
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_term)
      && $stable(out_sum) && $stable(out_est) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind taylor_series_exp_sin_evaluator tses_chk u_tses_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_term),
  .out_index (out_ch.term_index),
  .out_term  (out_ch.term_value),
  .out_sum   (out_ch.running_sum),
  .out_est   (out_ch.error_estimate)
);
`default_nettype wire
